@@ sv/gsm_pkg.sv @@
package gsm_pkg;

	localparam int IDX_W   = 3;
	localparam int SCORE_W = 16;
	localparam int ANGLE_W = 16;

	localparam logic [SCORE_W-1:0] MIN_SCORE_RST = 16'd16384;

	// one accepted matrix entry on its way to the solver
	typedef struct packed {
		logic                      keep;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic [SCORE_W-1:0]        score;
		logic signed [ANGLE_W-1:0] angle;
		logic                      last;
	} gsm_cmd_t;

	// one result item
	typedef struct packed {
		logic                      matched;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic signed [ANGLE_W-1:0] angle;
		logic                      run_end;
	} gsm_res_t;

endpackage

@@ sv/gsm_ram.sv @@
module gsm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/gsm_fifo.sv @@
module gsm_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rdata   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

@@ sv/gsm_front.sv @@
module gsm_front
	import gsm_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [IDX_W-1:0]          row_index,
	input  logic [IDX_W-1:0]          col_index,
	input  logic [SCORE_W-1:0]        score,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic                      last_entry,
	output logic                      cmd_valid,
	output gsm_cmd_t                  cmd,
	input  logic                      cmd_pop
);

	gsm_cmd_t              cmd_in;
	logic [$bits(gsm_cmd_t)-1:0] cmd_raw;
	logic                  cmd_empty;

	// drop the store, not the solve, for an entry outside the matrix
	always_comb begin
		cmd_in.keep  = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
		cmd_in.row   = row_index;
		cmd_in.col   = col_index;
		cmd_in.score = score;
		cmd_in.angle = angle;
		cmd_in.last  = last_entry;
	end

	gsm_fifo #(.W($bits(gsm_cmd_t))) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_raw),
		.empty (cmd_empty)
	);

	assign cmd       = gsm_cmd_t'(cmd_raw);
	assign cmd_valid = !cmd_empty;

endmodule

@@ sv/gsm_solver.sv @@
module gsm_solver
	import gsm_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SCORE_W-1:0] min_score,
	input  logic               cmd_valid,
	input  gsm_cmd_t           cmd,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output gsm_res_t           res
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int CCW   = $clog2(MAX_COLS + 1);
	localparam int DW    = SCORE_W + ANGLE_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_DECIDE = 2'd3;

	logic [1:0]                state_q;
	logic [RCW-1:0]            row_count_q;
	logic [CCW-1:0]            col_count_q;
	logic [MAX_ROWS-1:0]       row_used_q;
	logic [MAX_COLS-1:0]       col_used_q;
	logic [DEPTH-1:0]          written_q;
	logic [RIW-1:0]            i_q;
	logic [CIW-1:0]            j_q;
	logic                      rd_v_s1;
	logic                      elig_s1;
	logic [RIW-1:0]            rd_i_s1;
	logic [CIW-1:0]            rd_j_s1;
	logic [SCORE_W-1:0]        best_q;
	logic [RIW-1:0]            best_row_q;
	logic [CIW-1:0]            best_col_q;
	logic signed [ANGLE_W-1:0] best_angle_q;

	logic [AW-1:0]             wr_addr;
	logic [AW-1:0]             rd_addr;
	logic                      ram_we;
	logic [DW-1:0]             rd_data;
	logic [SCORE_W-1:0]        rd_score;
	logic [RCW-1:0]            row_next;
	logic [CCW-1:0]            col_next;
	logic                      col_wrap;
	logic                      row_wrap;
	logic                      accept_pick;
	logic                      matrix_empty;

	assign wr_addr  = AW'(32'(cmd.row) * MAX_COLS + 32'(cmd.col));
	assign rd_addr  = AW'(32'(i_q) * MAX_COLS + 32'(j_q));
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign ram_we   = cmd_pop && cmd.keep;
	assign rd_score = rd_data[DW-1 -: SCORE_W];
	assign row_next = RCW'({1'b0, cmd.row} + 4'd1);
	assign col_next = CCW'({1'b0, cmd.col} + 4'd1);
	assign col_wrap = (CCW'(j_q) + CCW'(1)) == col_count_q;
	assign row_wrap = (RCW'(i_q) + RCW'(1)) == row_count_q;
	assign matrix_empty = (row_count_q == '0) || (col_count_q == '0);
	assign accept_pick  = (best_q != '0) && (best_q >= min_score);

	gsm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_addr),
		.wdata({cmd.score, cmd.angle}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		res_push    = (state_q == ST_DECIDE) && !res_full;
		res.matched = accept_pick;
		res.row     = accept_pick ? IDX_W'(best_row_q) : '0;
		res.col     = accept_pick ? IDX_W'(best_col_q) : '0;
		res.angle   = accept_pick ? best_angle_q : '0;
		res.run_end = !accept_pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_count_q <= '0;
			col_count_q <= '0;
			row_used_q  <= '0;
			col_used_q  <= '0;
			written_q   <= '0;
			i_q         <= '0;
			j_q         <= '0;
			rd_v_s1     <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.keep) begin
							written_q[wr_addr] <= 1'b1;
							if (row_next > row_count_q) begin
								row_count_q <= row_next;
							end
							if (col_next > col_count_q) begin
								col_count_q <= col_next;
							end
						end
						if (cmd.last) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (matrix_empty) begin
						state_q <= ST_DECIDE;
					end else begin
						rd_v_s1 <= 1'b1;
						if (col_wrap) begin
							j_q <= '0;
							if (row_wrap) begin
								state_q <= ST_DRAIN;
							end else begin
								i_q <= i_q + RIW'(1);
							end
						end else begin
							j_q <= j_q + CIW'(1);
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!res_full) begin
						if (accept_pick) begin
							row_used_q[best_row_q] <= 1'b1;
							col_used_q[best_col_q] <= 1'b1;
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_SCAN;
						end else begin
							// close the run and start a fresh matrix
							row_count_q <= '0;
							col_count_q <= '0;
							row_used_q  <= '0;
							col_used_q  <= '0;
							written_q   <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read tag and running best; best clears whenever a new scan begins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if ((cmd_pop && cmd.last) || (res_push && accept_pick)) begin
			best_q <= '0;
		end else if (rd_v_s1 && elig_s1 && (rd_score > best_q)) begin
			best_q <= rd_score;
		end
	end

	always_ff @(posedge clk) begin
		elig_s1 <= written_q[rd_addr] && !row_used_q[i_q] && !col_used_q[j_q];
		rd_i_s1 <= i_q;
		rd_j_s1 <= j_q;
		if (rd_v_s1 && elig_s1 && (rd_score > best_q)) begin
			best_row_q   <= rd_i_s1;
			best_col_q   <= rd_j_s1;
			best_angle_q <= rd_data[ANGLE_W-1:0];
		end
	end

endmodule

@@ sv/greedy_score_matrix_matcher.sv @@
// Greedy score-matrix matcher.
// Input side is a queue: drive the entry fields with push; the entry is taken
// on a clock edge where push is high and full is low. Entries load one a cycle
// into the matrix memory through a two-deep request queue. The entry with
// last_entry set starts a solve; further entries wait in the queue until the
// run has closed.
// Result side is a queue: a result is on the ports while empty is low and is
// taken on an edge with pop high. Each run yields its matches best first, then
// one item with run_end set and matched clear.
// Throughput: one entry per cycle while loading. A solve makes, for each pick
// and for the closing item, one scan of the loaded rows x cols, one read a
// cycle on the matrix memory's single read port, then drain and decide states.
// A stalled result side holds the solver once the two-deep result queue fills.
// Write min_score (cfg_wen/cfg_wdata) only while the block is idle; the block
// does not enforce it. Reset clears the queues, the used masks, the counts and
// the written bits and sets min_score to 0.5; the matrix memory is not cleared.
module greedy_score_matrix_matcher
	import gsm_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [SCORE_W-1:0]        cfg_wdata,
	input  logic                      push,
	output logic                      full,
	input  logic [IDX_W-1:0]          row_index,
	input  logic [IDX_W-1:0]          col_index,
	input  logic [SCORE_W-1:0]        score,
	input  logic signed [ANGLE_W-1:0] angle,
	input  logic                      last_entry,
	output logic                      empty,
	input  logic                      pop,
	output logic                      matched,
	output logic [IDX_W-1:0]          match_row,
	output logic [IDX_W-1:0]          match_col,
	output logic signed [ANGLE_W-1:0] match_angle,
	output logic                      run_end
);

	logic [SCORE_W-1:0]          min_score_q;
	logic                        cmd_valid;
	gsm_cmd_t                    cmd;
	logic                        cmd_pop;
	logic                        res_full;
	logic                        res_push;
	gsm_res_t                    res_in;
	logic [$bits(gsm_res_t)-1:0] res_raw;
	gsm_res_t                    res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_score_q <= MIN_SCORE_RST;
		end else if (cfg_wen) begin
			min_score_q <= cfg_wdata;
		end
	end

	gsm_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.row_index (row_index),
		.col_index (col_index),
		.score     (score),
		.angle     (angle),
		.last_entry(last_entry),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	gsm_solver #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_solver (
		.clk      (clk),
		.arst_n   (arst_n),
		.min_score(min_score_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	gsm_fifo #(.W($bits(gsm_res_t))) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign res_out     = gsm_res_t'(res_raw);
	assign matched     = res_out.matched;
	assign match_row   = res_out.row;
	assign match_col   = res_out.col;
	assign match_angle = res_out.angle;
	assign run_end     = res_out.run_end;

endmodule
